/* sv/mdc_pkg.sv */
package mdc_pkg;

    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 8;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int TICKS_W    = 24;
    localparam int EXPECT_W   = 19;
    localparam int BASE_W     = 12;
    localparam int BEAT_W     = 11;
    localparam int CFG_W      = 8;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [TICKS_W-1:0] TICK_MAX = {TICKS_W{1'b1}};

    localparam logic [3:0] CODE_TUPLET  = 4'd14;
    localparam logic [3:0] CODE_INVALID = 4'd15;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DUR    = 3'd1,
        ST_BAD_TUPLET = 3'd2,
        ST_BAD_TSIG   = 3'd3,
        ST_MISMATCH   = 3'd4
    } t_status;

    typedef enum logic {
        CFG_NUMERATOR   = 1'b0,
        CFG_DENOMINATOR = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_ACC,
        BK_RPT
    } t_back_state;

    // one classified note as it travels from front to back
    typedef struct packed {
        t_status                 err;
        logic                    need_div;
        logic                    last;
        logic [DIVIDEND_W-1:0]   dividend;
        logic [DIVISOR_W-1:0]    divisor;
    } t_work;

    // ticks of a plain note at 1920 per whole note
    function automatic logic [BASE_W-1:0] base_ticks(input logic [3:0] code);
        logic [BASE_W-1:0] t;
        case (code)
            4'd0:    t = 12'd2880;
            4'd1:    t = 12'd1920;
            4'd2:    t = 12'd1440;
            4'd3:    t = 12'd960;
            4'd4:    t = 12'd720;
            4'd5:    t = 12'd480;
            4'd6:    t = 12'd360;
            4'd7:    t = 12'd240;
            4'd8:    t = 12'd180;
            4'd9:    t = 12'd120;
            4'd10:   t = 12'd90;
            4'd11:   t = 12'd60;
            4'd12:   t = 12'd30;
            4'd13:   t = 12'd15;
            default: t = 12'd0;
        endcase
        return t;
    endfunction

    function automatic logic [BEAT_W-1:0] beat_len(input logic [CFG_W-1:0] den);
        logic [BEAT_W-1:0] t;
        case (den)
            8'd1:    t = 11'd1920;
            8'd2:    t = 11'd960;
            8'd4:    t = 11'd480;
            8'd8:    t = 11'd240;
            8'd16:   t = 11'd120;
            8'd32:   t = 11'd60;
            8'd64:   t = 11'd30;
            default: t = 11'd0;
        endcase
        return t;
    endfunction

endpackage

/* sv/mdc_note_if.sv */
interface mdc_note_if;
    logic       valid;
    logic       ready;
    logic [3:0] duration_code;
    logic [7:0] tuplet_count;
    logic [7:0] tuplet_span;
    logic [3:0] tuplet_base_code;
    logic       last_note;

    modport source (
        output valid, duration_code, tuplet_count, tuplet_span, tuplet_base_code,
               last_note,
        input  ready
    );
    modport sink (
        input  valid, duration_code, tuplet_count, tuplet_span, tuplet_base_code,
               last_note,
        output ready
    );
endinterface

/* sv/mdc_result_if.sv */
interface mdc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  measure_status;
    logic [23:0] measure_ticks;
    logic [18:0] target_ticks;

    modport source (
        output valid, measure_status, measure_ticks, target_ticks,
        input  ready
    );
    modport sink (
        input  valid, measure_status, measure_ticks, target_ticks,
        output ready
    );
endinterface

/* sv/mdc_front.sv */
module mdc_front
    import mdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdc_note_if.sink    i_note,
    output t_work       o_work,
    output logic        o_work_valid,
    input  logic        i_work_ready
);

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  take;

    logic [BASE_W-1:0] tup_base;

    assign i_note.ready = !r_valid || i_work_ready;
    assign take         = i_note.valid && i_note.ready;
    assign tup_base     = base_ticks(i_note.tuplet_base_code);

    always_comb begin
        n_work          = '0;
        n_work.err      = ST_OK;
        n_work.last     = i_note.last_note;
        n_work.divisor  = i_note.tuplet_count;
        if (i_note.duration_code == CODE_TUPLET) begin
            if (i_note.tuplet_count == '0 || i_note.tuplet_span == '0) begin
                n_work.err = ST_BAD_TUPLET;
            end else if (i_note.tuplet_base_code == CODE_TUPLET) begin
                n_work.err = ST_BAD_TUPLET;
            end else if (i_note.tuplet_base_code == CODE_INVALID) begin
                n_work.err = ST_BAD_DUR;
            end else begin
                n_work.need_div = 1'b1;
                n_work.dividend = DIVIDEND_W'(tup_base * i_note.tuplet_span);
            end
        end else if (i_note.duration_code == CODE_INVALID) begin
            n_work.err = ST_BAD_DUR;
        end else begin
            n_work.dividend = DIVIDEND_W'(base_ticks(i_note.duration_code));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_work_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_work <= n_work;
        end
    end

    assign o_work       = r_work;
    assign o_work_valid = r_valid;

endmodule

/* sv/mdc_fifo.sv */
module mdc_fifo
    import mdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_work i_wr_data,
    input  logic  i_wr_valid,
    output logic  o_wr_ready,
    output t_work o_rd_data,
    output logic  o_rd_valid,
    input  logic  i_rd_ready
);

    t_work                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  push;
    logic                  pop;

    assign o_wr_ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* sv/mdc_back.sv */
module mdc_back
    import mdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_numerator,
    input  logic [CFG_W-1:0] i_denominator,
    input  t_work            i_work,
    input  logic             i_work_valid,
    output logic             o_work_ready,
    mdc_result_if.source     o_result
);

    t_back_state r_state, n_state;

    logic [TICKS_W-1:0]    r_running_ticks, n_running_ticks;
    t_status               r_first_err, n_first_err;
    t_status               r_err, n_err;
    logic                  r_last, n_last;
    logic [DIVIDEND_W-1:0] r_quot, n_quot;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_divisor, n_divisor;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;

    logic                  r_res_valid, n_res_valid;
    t_status               r_res_status, n_res_status;
    logic [TICKS_W-1:0]    r_res_total, n_res_total;
    logic [EXPECT_W-1:0]   r_res_expected, n_res_expected;

    logic [DIVISOR_W:0]    rem_sh;
    logic                  q_bit;
    logic [TICKS_W:0]      sum;
    logic [BEAT_W-1:0]     beat;
    logic [EXPECT_W-1:0]   expected;
    logic                  tsig_bad;
    logic                  res_free;

    // one quotient bit per cycle, restoring
    assign rem_sh   = {r_rem, r_quot[DIVIDEND_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_divisor});
    assign sum      = {1'b0, r_running_ticks} + (TICKS_W + 1)'(r_quot);
    assign beat     = beat_len(i_denominator);
    assign expected = EXPECT_W'(i_numerator * beat);
    assign tsig_bad = (i_numerator == '0) || (beat == '0);
    assign res_free = !r_res_valid || o_result.ready;

    always_comb begin
        n_state         = r_state;
        n_running_ticks = r_running_ticks;
        n_first_err     = r_first_err;
        n_err           = r_err;
        n_last          = r_last;
        n_quot          = r_quot;
        n_rem           = r_rem;
        n_divisor       = r_divisor;
        n_cnt           = r_cnt;
        n_res_valid     = r_res_valid && !o_result.ready;
        n_res_status    = r_res_status;
        n_res_total     = r_res_total;
        n_res_expected  = r_res_expected;
        o_work_ready    = 1'b0;

        case (r_state)
            BK_IDLE: begin
                o_work_ready = 1'b1;
                if (i_work_valid) begin
                    n_err     = i_work.err;
                    n_last    = i_work.last;
                    n_quot    = i_work.dividend;
                    n_divisor = i_work.divisor;
                    n_rem     = '0;
                    n_cnt     = '0;
                    if (i_work.need_div && i_work.err == ST_OK && r_first_err == ST_OK) begin
                        n_state = BK_DIV;
                    end else begin
                        n_state = BK_ACC;
                    end
                end
            end
            BK_DIV: begin
                n_quot = {r_quot[DIVIDEND_W-2:0], q_bit};
                n_rem  = q_bit ? DIVISOR_W'(rem_sh - {1'b0, r_divisor})
                               : DIVISOR_W'(rem_sh);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = BK_ACC;
                end
            end
            BK_ACC: begin
                if (r_first_err == ST_OK) begin
                    if (r_err != ST_OK) begin
                        n_first_err = r_err;
                    end else begin
                        n_running_ticks = sum[TICKS_W] ? TICK_MAX : sum[TICKS_W-1:0];
                    end
                end
                n_state = r_last ? BK_RPT : BK_IDLE;
            end
            BK_RPT: begin
                if (res_free) begin
                    n_res_valid = 1'b1;
                    n_res_total = r_running_ticks;
                    if (tsig_bad) begin
                        n_res_status   = ST_BAD_TSIG;
                        n_res_expected = '0;
                    end else begin
                        n_res_expected = expected;
                        if (r_first_err != ST_OK) begin
                            n_res_status = r_first_err;
                        end else if (r_running_ticks != TICKS_W'(expected)) begin
                            n_res_status = ST_MISMATCH;
                        end else begin
                            n_res_status = ST_OK;
                        end
                    end
                    n_running_ticks = '0;
                    n_first_err     = ST_OK;
                    n_state         = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= BK_IDLE;
            r_running_ticks <= '0;
            r_first_err     <= ST_OK;
            r_res_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_running_ticks <= n_running_ticks;
            r_first_err     <= n_first_err;
            r_res_valid     <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err          <= n_err;
        r_last         <= n_last;
        r_quot         <= n_quot;
        r_rem          <= n_rem;
        r_divisor      <= n_divisor;
        r_cnt          <= n_cnt;
        r_res_status   <= n_res_status;
        r_res_total    <= n_res_total;
        r_res_expected <= n_res_expected;
    end

    assign o_result.valid          = r_res_valid;
    assign o_result.measure_status = r_res_status;
    assign o_result.measure_ticks  = r_res_total;
    assign o_result.target_ticks   = r_res_expected;

`ifndef SYNTHESIS
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DIV |-> r_cnt <= DIV_CNT_W'(DIV_STEPS - 1))
        else $error("divider step count out of range");

    a_err_freezes_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_ACC && r_first_err != ST_OK) |=> $stable(r_running_ticks))
        else $error("ticks added after a note error");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RPT && res_free) |=> (r_running_ticks == '0 && r_first_err == ST_OK))
        else $error("measure state not cleared after report");

    a_tsig_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_status == ST_BAD_TSIG) |-> r_res_expected == '0)
        else $error("expected ticks nonzero on time signature error");
`endif

endmodule

/* sv/measure_duration_checker_unit.sv */
// Measure duration checker.
// i_note carries one note per transfer (plain duration code or tuplet);
// o_result carries one status per measure, sent on the note flagged
// last_note. Time signature registers are written through i_cfg_we,
// i_cfg_idx (0 numerator, 1 denominator) and i_cfg_data; the user must
// write them only while idle, the block itself does not enforce it.
// A front stage classifies each note and computes the tuplet dividend,
// a two-entry queue decouples it from the back end, which divides,
// accumulates and reports.
// In the back end a plain or erroneous note passes the idle and
// accumulate states; a tuplet that still counts also passes the 20-step
// bit-serial divider (one quotient bit per cycle). The last note of a
// measure adds a report state. The front accepts one note per cycle
// until the queue fills.
// Reset clears the running total, the kept error and all valid flags,
// and sets the time signature to 4/4. When the receiver stalls, the
// result waits in the output register; the back end keeps working on
// later notes and stops only when it has a new result to send.
module measure_duration_checker_unit
    import mdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    mdc_note_if.sink         i_note,
    mdc_result_if.source     o_result
);

    logic [CFG_W-1:0] r_numerator;
    logic [CFG_W-1:0] r_denominator;

    t_work front_work;
    logic  front_valid;
    logic  front_ready;
    t_work back_work;
    logic  back_valid;
    logic  back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator   <= CFG_W'(4);
            r_denominator <= CFG_W'(4);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMERATOR:   r_numerator   <= i_cfg_data;
                CFG_DENOMINATOR: r_denominator <= i_cfg_data;
                default:         r_numerator   <= r_numerator;
            endcase
        end
    end

    mdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_note       (i_note),
        .o_work       (front_work),
        .o_work_valid (front_valid),
        .i_work_ready (front_ready)
    );

    mdc_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_data  (front_work),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .o_rd_data  (back_work),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready)
    );

    mdc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_numerator   (r_numerator),
        .i_denominator (r_denominator),
        .i_work        (back_work),
        .i_work_valid  (back_valid),
        .o_work_ready  (back_ready),
        .o_result      (o_result)
    );

endmodule
